// ----- rtl/core/packed_pixel_palette_expander_macros.svh -----
// assertion macros for the palette expander checker
`ifndef PACKED_PIXEL_PALETTE_EXPANDER_MACROS_SVH
`define PACKED_PIXEL_PALETTE_EXPANDER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define PPX_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ppx assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define PPX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ppx assertion failed");

`endif

// ----- rtl/core/ppx_pkg.sv -----
package ppx_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int COUNT_BITS_DEF    = 16;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [1:0] REG_FORMAT = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [4:0]  FORMAT_RESET = 5'd0;
   localparam logic [15:0] WIDTH_RESET  = 16'd1;
   localparam logic [15:0] HEIGHT_RESET = 16'd1;

   localparam logic [4:0] MODE_BYTE         = 5'd0;
   localparam logic [4:0] MODE_BIT_FIRST    = 5'd1;
   localparam logic [4:0] MODE_BIT_LAST     = 5'd7;
   localparam logic [4:0] MODE_DIBIT_FIRST  = 5'd8;
   localparam logic [4:0] MODE_DIBIT_LAST   = 5'd12;
   localparam logic [4:0] MODE_NIBBLE_FIRST = 5'd13;
   localparam logic [4:0] MODE_NIBBLE_LAST  = 5'd17;
   localparam logic [4:0] MODE_HOLD         = 5'd18;

   // last sub-mode offset that is msb first
   localparam logic [4:0] BIT_MSB_LAST   = 5'd3;
   localparam logic [4:0] MULTI_MSB_LAST = 5'd2;

   // upper two bits of a hold-modify code
   localparam logic [1:0] HOLD_LOAD  = 2'b00;
   localparam logic [1:0] HOLD_BLUE  = 2'b01;
   localparam logic [1:0] HOLD_RED   = 2'b10;
   localparam logic [1:0] HOLD_GREEN = 2'b11;

   // 16-bit aligned rows skip a pad byte for width mod 16 in 1..8
   localparam logic [3:0] PAD_WIDTH_MAX = 4'd8;

   typedef enum logic [1:0] {BPP1, BPP2, BPP4, BPP8} bpp_type;

   typedef enum logic [2:0] {
      RULE_ALIGN, RULE_CONT, RULE_WORD, RULE_LOW, RULE_BYTE, RULE_HOLD
   } rule_type;

   localparam rule_type BIT_RULES [7] = '{
      RULE_ALIGN, RULE_CONT, RULE_WORD, RULE_LOW, RULE_ALIGN, RULE_CONT, RULE_WORD
   };
   localparam rule_type MULTI_RULES [5] = '{
      RULE_ALIGN, RULE_CONT, RULE_LOW, RULE_ALIGN, RULE_CONT
   };

   typedef struct packed {
      logic     ok;
      bpp_type  bpp;
      logic     msb;
      rule_type rule;
   } fmt_type;

   typedef struct packed {
      logic [4:0]  format_mode;
      logic [15:0] image_width;
      logic [15:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic       hold;
      logic       load;
      logic [5:0] code;
      logic       row_end;
      logic       image_end;
      logic       last_of_byte;
   } pix_type;

   typedef struct packed {
      logic       en;
      logic [7:0] idx;
   } rd_req_type;

   typedef struct packed {
      logic        en;
      logic [7:0]  idx;
      logic [63:0] color;
   } wr_req_type;

   function automatic fmt_type decode_fmt(input logic [4:0] mode);
      fmt_type    f;
      logic [4:0] s;
      f.ok   = 1'b1;
      f.bpp  = BPP8;
      f.msb  = 1'b1;
      f.rule = RULE_BYTE;
      s      = '0;
      unique case (mode) inside
         MODE_BYTE: begin
            f.rule = RULE_BYTE;
         end
         [MODE_BIT_FIRST:MODE_BIT_LAST]: begin
            s      = mode - MODE_BIT_FIRST;
            f.bpp  = BPP1;
            f.msb  = (s <= BIT_MSB_LAST);
            f.rule = BIT_RULES[s[2:0]];
         end
         [MODE_DIBIT_FIRST:MODE_DIBIT_LAST]: begin
            s      = mode - MODE_DIBIT_FIRST;
            f.bpp  = BPP2;
            f.msb  = (s <= MULTI_MSB_LAST);
            f.rule = MULTI_RULES[s[2:0]];
         end
         [MODE_NIBBLE_FIRST:MODE_NIBBLE_LAST]: begin
            s      = mode - MODE_NIBBLE_FIRST;
            f.bpp  = BPP4;
            f.msb  = (s <= MULTI_MSB_LAST);
            f.rule = MULTI_RULES[s[2:0]];
         end
         MODE_HOLD: begin
            f.rule = RULE_HOLD;
         end
         default: begin
            f.ok = 1'b0;
         end
      endcase
      return f;
   endfunction

   function automatic logic [3:0] bpp_bits(input bpp_type b);
      logic [3:0] r;
      case (b)
         BPP1:    r = 4'd1;
         BPP2:    r = 4'd2;
         BPP4:    r = 4'd4;
         default: r = 4'd8;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] bpp_mask(input bpp_type b);
      logic [7:0] r;
      case (b)
         BPP1:    r = 8'h01;
         BPP2:    r = 8'h03;
         BPP4:    r = 8'h0F;
         default: r = 8'hFF;
      endcase
      return r;
   endfunction

   // pixels per byte minus one
   function automatic logic [2:0] ppb_left(input bpp_type b);
      logic [2:0] r;
      case (b)
         BPP1:    r = 3'd7;
         BPP2:    r = 3'd3;
         BPP4:    r = 3'd1;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   // nibble times 17 in both bytes
   function automatic logic [15:0] nib_fill(input logic [3:0] n);
      return {n, n, n, n};
   endfunction

endpackage

// ----- rtl/core/ppx_if.sv -----
interface ppx_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_byte;
   logic [7:0]  entry_index;
   logic [15:0] entry_red;
   logic [15:0] entry_green;
   logic [15:0] entry_blue;
   logic [15:0] entry_alpha;

   modport source (
      output valid, kind, data_byte, entry_index, entry_red, entry_green, entry_blue,
             entry_alpha,
      input  ready
   );
   modport sink (
      input  valid, kind, data_byte, entry_index, entry_red, entry_green, entry_blue,
             entry_alpha,
      output ready
   );
endinterface

interface ppx_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_red;
   logic [15:0] pixel_green;
   logic [15:0] pixel_blue;
   logic [15:0] pixel_alpha;
   logic        row_end;
   logic        image_end;
   logic        last_of_byte;

   modport source (
      output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha, row_end, image_end,
             last_of_byte,
      input  ready
   );
   modport sink (
      input  valid, pixel_red, pixel_green, pixel_blue, pixel_alpha, row_end, image_end,
             last_of_byte,
      output ready
   );
endinterface

// ----- rtl/core/ppx_csr.sv -----
module ppx_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ppx_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ppx_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ppx_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output ppx_pkg::cfg_type                    cfg
);

   ppx_pkg::cfg_type cfg_ff;
   ppx_pkg::cfg_type cfg_in;
   logic [1:0]       reg_idx;
   logic             wr_en;

   always_comb begin
      reg_idx = paddr[ppx_pkg::CSR_ADDR_BITS-1:2];
      wr_en   = psel && penable && pwrite;
      cfg_in  = cfg_ff;
      prdata  = '0;
      unique case (reg_idx)
         ppx_pkg::REG_FORMAT: begin
            prdata = ppx_pkg::CSR_DATA_BITS'(cfg_ff.format_mode);
            if (wr_en) begin
               cfg_in.format_mode = pwdata[4:0];
            end
         end
         ppx_pkg::REG_WIDTH: begin
            prdata = ppx_pkg::CSR_DATA_BITS'(cfg_ff.image_width);
            if (wr_en) begin
               cfg_in.image_width = pwdata[15:0];
            end
         end
         ppx_pkg::REG_HEIGHT: begin
            prdata = ppx_pkg::CSR_DATA_BITS'(cfg_ff.image_height);
            if (wr_en) begin
               cfg_in.image_height = pwdata[15:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format_mode  <= ppx_pkg::FORMAT_RESET;
         cfg_ff.image_width  <= ppx_pkg::WIDTH_RESET;
         cfg_ff.image_height <= ppx_pkg::HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

// ----- rtl/core/ppx_unpack.sv -----
module ppx_unpack #(
   parameter int COUNT_BITS = ppx_pkg::COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ppx_req_if.sink              req_bus,
   input  ppx_pkg::cfg_type     cfg,
   input  logic                 s2_ready,
   output ppx_pkg::pix_type     pix,
   output ppx_pkg::rd_req_type  rd_req,
   output ppx_pkg::wr_req_type  wr_req
);

   logic                  busy_ff, busy_in;
   logic [7:0]            shift_ff, shift_in;
   ppx_pkg::fmt_type      fmt_ff, fmt_in, fmt_new;
   logic [2:0]            left_ff, left_in;
   logic [COUNT_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [COUNT_BITS-1:0] col_inc, row_inc, width_c, height_c;
   logic                  skip_ff, skip_in;
   logic                  fire, last, re, ie, accept, drop, msb_sel, word_pad;
   logic [7:0]            idx;
   logic [5:0]            code;

   always_comb begin
      width_c  = COUNT_BITS'(cfg.image_width);
      height_c = COUNT_BITS'(cfg.image_height);
      fire     = busy_ff && s2_ready;

      msb_sel = fmt_ff.msb && (fmt_ff.rule != ppx_pkg::RULE_LOW);
      if (msb_sel) begin
         case (fmt_ff.bpp)
            ppx_pkg::BPP1: idx = {7'b0, shift_ff[7]};
            ppx_pkg::BPP2: idx = {6'b0, shift_ff[7:6]};
            ppx_pkg::BPP4: idx = {4'b0, shift_ff[7:4]};
            default:       idx = shift_ff;
         endcase
      end else begin
         idx = shift_ff & ppx_pkg::bpp_mask(fmt_ff.bpp);
      end
      code = shift_ff[5:0];

      col_inc  = col_ff + 1'b1;
      row_inc  = row_ff + 1'b1;
      re       = (col_inc == width_c);
      ie       = re && (row_inc == height_c);
      last     = (left_ff == '0) || ie || (re && (fmt_ff.rule != ppx_pkg::RULE_CONT));
      word_pad = (cfg.image_width[3:0] != '0) && (cfg.image_width[3:0] <= ppx_pkg::PAD_WIDTH_MAX);

      busy_in  = busy_ff;
      shift_in = shift_ff;
      fmt_in   = fmt_ff;
      left_in  = left_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      skip_in  = skip_ff;

      if (fire) begin
         if (fmt_ff.msb) begin
            shift_in = shift_ff << ppx_pkg::bpp_bits(fmt_ff.bpp);
         end else begin
            shift_in = shift_ff >> ppx_pkg::bpp_bits(fmt_ff.bpp);
         end
         left_in = left_ff - 1'b1;
         col_in  = re ? '0 : col_inc;
         row_in  = re ? row_inc : row_ff;
         if (re && !ie && (fmt_ff.rule == ppx_pkg::RULE_WORD) && word_pad) begin
            skip_in = 1'b1;
         end
         if (last) begin
            busy_in = 1'b0;
         end
      end

      req_bus.ready = !busy_ff || (fire && last);
      accept        = req_bus.valid && req_bus.ready;
      fmt_new       = ppx_pkg::decode_fmt(cfg.format_mode);
      drop          = skip_in || (row_in == height_c) || !fmt_new.ok;

      if (accept && !req_bus.kind) begin
         if (skip_in) begin
            skip_in = 1'b0;
         end else if (!drop) begin
            busy_in  = 1'b1;
            shift_in = req_bus.data_byte;
            fmt_in   = fmt_new;
            // low-bits modes give one pixel per byte
            left_in  = (fmt_new.rule == ppx_pkg::RULE_LOW) ? '0 : ppx_pkg::ppb_left(fmt_new.bpp);
         end
      end

      wr_req.en    = accept && req_bus.kind;
      wr_req.idx   = req_bus.entry_index;
      wr_req.color = {req_bus.entry_red, req_bus.entry_green, req_bus.entry_blue,
                      req_bus.entry_alpha};

      rd_req.en = fire;
      if (fmt_ff.rule == ppx_pkg::RULE_HOLD) begin
         rd_req.idx = (code[5:4] == ppx_pkg::HOLD_LOAD) ? {2'b00, code} : '0;
      end else begin
         rd_req.idx = idx;
      end

      pix.valid        = fire;
      pix.hold         = (fmt_ff.rule == ppx_pkg::RULE_HOLD);
      pix.load         = (code[5:4] == ppx_pkg::HOLD_LOAD) || (col_ff == '0);
      pix.code         = code;
      pix.row_end      = re;
      pix.image_end    = ie;
      pix.last_of_byte = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fmt_ff  <= '0;
         left_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
         skip_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fmt_ff  <= fmt_in;
         left_ff <= left_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         skip_ff <= skip_in;
      end
      shift_ff <= shift_in;
   end

endmodule

// ----- rtl/core/ppx_palette.sv -----
module ppx_palette #(
   parameter int TABLE_ENTRIES = ppx_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ppx_pkg::rd_req_type rd_req,
   input  ppx_pkg::wr_req_type wr_req,
   output logic [63:0]         rd_color
);

   localparam int ADDR_BITS = $clog2(TABLE_ENTRIES);

   logic [63:0]              mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [63:0]              rd_data_ff;
   logic                     rd_ok_ff;
   logic                     rd_hit, wr_hit;
   logic [ADDR_BITS-1:0]     rd_addr, wr_addr;

   always_comb begin
      rd_hit  = int'(rd_req.idx) < TABLE_ENTRIES;
      wr_hit  = int'(wr_req.idx) < TABLE_ENTRIES;
      rd_addr = rd_req.idx[ADDR_BITS-1:0];
      wr_addr = wr_req.idx[ADDR_BITS-1:0];
   end

   // read returns the old entry when both ports hit the same address
   always_ff @(posedge clock) begin
      if (wr_req.en && wr_hit) begin
         mem[wr_addr] <= wr_req.color;
      end
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_req.en && wr_hit) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_req.en) begin
            rd_ok_ff <= rd_hit && valid_ff[rd_addr];
         end
      end
   end

   assign rd_color = rd_ok_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/core/ppx_output.sv -----
module ppx_output (
   input  logic             clock,
   input  logic             reset,
   input  ppx_pkg::pix_type pix,
   input  logic [63:0]      rd_color,
   output logic             s2_ready,
   ppx_rsp_if.source        rsp_bus
);

   ppx_pkg::pix_type s2_ff, s2_in;
   logic [63:0]      held_ff, held_in;
   logic [63:0]      base, color;
   logic [15:0]      fill;
   logic             out_valid_ff, out_valid_in;
   logic [63:0]      out_color_ff, out_color_in;
   logic [2:0]       out_flags_ff, out_flags_in;
   logic             out_free, move;

   always_comb begin
      out_free = !out_valid_ff || rsp_bus.ready;
      s2_ready = !s2_ff.valid || out_free;
      move     = s2_ff.valid && out_free;

      base = s2_ff.load ? rd_color : held_ff;
      fill = ppx_pkg::nib_fill(s2_ff.code[3:0]);
      if (!s2_ff.hold) begin
         color = rd_color;
      end else begin
         case (s2_ff.code[5:4])
            ppx_pkg::HOLD_LOAD: color = rd_color;
            ppx_pkg::HOLD_BLUE: color = {base[63:32], fill, base[15:0]};
            ppx_pkg::HOLD_RED:  color = {fill, base[47:0]};
            default:            color = {base[63:48], fill, base[31:0]};
         endcase
      end

      s2_in = s2_ff;
      if (pix.valid) begin
         s2_in = pix;
      end else if (move) begin
         s2_in.valid = 1'b0;
      end

      held_in = (move && s2_ff.hold) ? color : held_ff;

      out_valid_in = out_valid_ff;
      out_color_in = out_color_ff;
      out_flags_in = out_flags_ff;
      if (move) begin
         out_valid_in = 1'b1;
         out_color_in = color;
         out_flags_in = {s2_ff.row_end, s2_ff.image_end, s2_ff.last_of_byte};
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff        <= '0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_ff        <= s2_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
      out_color_ff <= out_color_in;
      out_flags_ff <= out_flags_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.pixel_red    = out_color_ff[63:48];
   assign rsp_bus.pixel_green  = out_color_ff[47:32];
   assign rsp_bus.pixel_blue   = out_color_ff[31:16];
   assign rsp_bus.pixel_alpha  = out_color_ff[15:0];
   assign rsp_bus.row_end      = out_flags_ff[2];
   assign rsp_bus.image_end    = out_flags_ff[1];
   assign rsp_bus.last_of_byte = out_flags_ff[0];

endmodule

// ----- rtl/core/packed_pixel_palette_expander.sv -----
// Packed pixel palette expander.
// req_bus carries one request per handshake: a palette entry write (kind 1) or a
// packed bitmap byte (kind 0). Each byte is split into 1, 2, 4 or 8 bit indices
// according to format_mode, each index is looked up in the palette memory and one
// RGBA16 pixel per index leaves on rsp_bus, with row, image and byte end flags.
// format_mode, image_width and image_height sit on the APB port at 0x0, 0x4, 0x8;
// write them only while no pixels are in flight.
// A byte's pixels pass the unpacker, lookup and output registers in turn.
// Throughput: one pixel per cycle while rsp_bus takes pixels, set by the single
// read port of the palette memory; a byte occupies the unpacker until it has
// yielded all its pixels (1 to 8), and the next request is taken in the cycle of
// its last pixel. Palette writes and dropped bytes (pad bytes, bytes past the
// last row, unknown formats) give no pixel.
// Reset clears the counters, the held color and the valid bits of all palette
// entries at once, so every entry reads as zero until written; no sweep is needed.
// When rsp_bus stalls, the output register holds its pixel, the lookup stage and
// the unpacker stop in turn, and req_bus ready drops once the unpacker is full.
module packed_pixel_palette_expander #(
   parameter int TABLE_ENTRIES = ppx_pkg::TABLE_ENTRIES_DEF,
   parameter int COUNT_BITS    = ppx_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   ppx_req_if.sink                            req_bus,
   ppx_rsp_if.source                          rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ppx_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [ppx_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [ppx_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   ppx_pkg::cfg_type    cfg;
   ppx_pkg::pix_type    pix;
   ppx_pkg::rd_req_type rd_req;
   ppx_pkg::wr_req_type wr_req;
   logic [63:0]         rd_color;
   logic                s2_ready;

   ppx_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ppx_unpack #(
      .COUNT_BITS (COUNT_BITS)
   ) u_unpack (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cfg      (cfg),
      .s2_ready (s2_ready),
      .pix      (pix),
      .rd_req   (rd_req),
      .wr_req   (wr_req)
   );

   ppx_palette #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_palette (
      .clock    (clock),
      .reset    (reset),
      .rd_req   (rd_req),
      .wr_req   (wr_req),
      .rd_color (rd_color)
   );

   ppx_output u_output (
      .clock    (clock),
      .reset    (reset),
      .pix      (pix),
      .rd_color (rd_color),
      .s2_ready (s2_ready),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ----- rtl/core/ppx_checker.sv -----
`include "packed_pixel_palette_expander_macros.svh"

module ppx_checker (
   input logic       clock,
   input logic       reset,
   ppx_rsp_if.source rsp_bus
);

   logic [66:0] rsp_word;

   assign rsp_word = {rsp_bus.pixel_red, rsp_bus.pixel_green, rsp_bus.pixel_blue,
                      rsp_bus.pixel_alpha, rsp_bus.row_end, rsp_bus.image_end,
                      rsp_bus.last_of_byte};

   `PPX_ASSERT_NEXT(a_rsp_hold, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid && $stable(rsp_word))
   `PPX_ASSERT_IMPLY(a_image_ends_row, rsp_bus.valid && rsp_bus.image_end, rsp_bus.row_end)
   `PPX_ASSERT_IMPLY(a_image_ends_byte, rsp_bus.valid && rsp_bus.image_end, rsp_bus.last_of_byte)
   `PPX_ASSERT_IMPLY(a_reset_empty, $past(reset), !rsp_bus.valid)

endmodule

bind packed_pixel_palette_expander ppx_checker u_ppx_checker (
   .clock   (clock),
   .reset   (reset),
   .rsp_bus (rsp_bus)
);
